// ===== design/cwa_pkg.sv =====
// Shared types and constants for the credit worker arbiter.
// Depends on nothing; used by credit_worker_arbiter.
package cwa_pkg;

    localparam int NUM_WORKERS_DEF = 16;
    localparam int CREDIT_W        = 8;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;
    localparam int WORKER_W        = 4;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX       = 8'hFF;
    localparam logic [CREDIT_W-1:0] INIT_CREDIT_RST  = 8'd4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GRANT  = 2'd2,
        OP_RETURN = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_NOCREDIT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RETURN,
        S_SCAN,
        S_SCAN_END,
        S_GRANT
    } state_t;

endpackage

// ===== design/credit_worker_arbiter.sv =====
// Credit worker arbiter, top level. Uses cwa_pkg and cwa_ram (credit store).
// Add and remove finish in the execute state; return reads the credit and writes it back;
// grant reads one credit entry per cycle from the RAM over all slots, then grants the best.
// A new beat may be accepted in the same cycle that done is high. done cannot be stalled.
// Reset (rst_n low, asynchronous) empties all slots and sets initial_credit to 4.
module credit_worker_arbiter #(
    parameter int NUM_WORKERS = cwa_pkg::NUM_WORKERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command channel.
    input  logic                          start,
    output logic                          busy,
    input  logic [cwa_pkg::OP_W-1:0]      operation,
    input  logic [cwa_pkg::WORKER_W-1:0]  worker,
    // Result channel.
    output logic                          done,
    output logic [cwa_pkg::STATUS_W-1:0]  status,
    output logic [cwa_pkg::WORKER_W-1:0]  granted_worker,
    // Configuration register.
    input  logic                          initial_credit_we,
    input  logic [cwa_pkg::CREDIT_W-1:0]  initial_credit
);

    localparam int IDX_W = $clog2(NUM_WORKERS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORKERS - 1);

    // Sequencer state and the captured command.
    cwa_pkg::state_t  state_reg, state_next;
    cwa_pkg::op_t     op_reg;
    logic [cwa_pkg::WORKER_W-1:0] worker_reg;

    logic [cwa_pkg::CREDIT_W-1:0] initial_credit_reg;

    // The present vector doubles as the valid bits of the credit RAM: the
    // credit of an absent slot is never used, so the RAM needs no clearing.
    logic [NUM_WORKERS-1:0] present_reg, present_next;
    logic [IDX_W-1:0]       last_winner_reg, last_winner_next;
    logic                   any_winner_reg, any_winner_next;

    // Scan pointer, the compare stage that trails it by the RAM read latency,
    // and the best candidate found so far.
    logic [IDX_W-1:0]             scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]             cmp_idx_reg, cmp_idx_next;
    logic                         cmp_vld_reg, cmp_vld_next;
    logic                         best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]             best_idx_reg, best_idx_next;
    logic [cwa_pkg::CREDIT_W-1:0] best_credit_reg, best_credit_next;
    logic                         best_above_reg, best_above_next;

    // Result register.
    logic                              done_reg, done_next;
    cwa_pkg::status_t                  status_reg, status_next;
    logic [cwa_pkg::WORKER_W-1:0]      granted_reg, granted_next;

    // Credit RAM port.
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [cwa_pkg::CREDIT_W-1:0] ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [cwa_pkg::CREDIT_W-1:0] ram_rdata;

    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] worker_idx;
    logic             worker_present;
    logic             cand_above;
    logic             cand_take;

    assign busy   = (state_reg != cwa_pkg::S_IDLE);
    assign accept = start && !busy;

    assign in_range       = (32'(worker_reg) < NUM_WORKERS);
    assign worker_idx     = IDX_W'(worker_reg);
    assign worker_present = in_range && present_reg[worker_idx];

    // The one compare unit: it looks at the entry read in the previous cycle
    // and decides whether it beats the best candidate so far. A tie is won
    // only by a slot above the last winner against one that is not above it.
    assign cand_above = !any_winner_reg || (cmp_idx_reg > last_winner_reg);
    assign cand_take  = cmp_vld_reg && present_reg[cmp_idx_reg]
                        && (ram_rdata != '0)
                        && (!best_vld_reg || (ram_rdata > best_credit_reg)
                            || ((ram_rdata == best_credit_reg) && cand_above
                                && !best_above_reg));

    cwa_ram #(
        .WIDTH (cwa_pkg::CREDIT_W),
        .DEPTH (NUM_WORKERS)
    ) u_credit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cwa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cwa_pkg::S_EXEC;
                end
            end
            cwa_pkg::S_EXEC:
            begin
                case (op_reg)
                    cwa_pkg::OP_RETURN: state_next = cwa_pkg::S_RETURN;
                    cwa_pkg::OP_GRANT:  state_next = cwa_pkg::S_SCAN;
                    default:            state_next = cwa_pkg::S_IDLE;
                endcase
            end
            cwa_pkg::S_RETURN:
            begin
                state_next = cwa_pkg::S_IDLE;
            end
            cwa_pkg::S_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = cwa_pkg::S_SCAN_END;
                end
            end
            cwa_pkg::S_SCAN_END:
            begin
                state_next = cwa_pkg::S_GRANT;
            end
            cwa_pkg::S_GRANT:
            begin
                state_next = cwa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cwa_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result.
    always_comb
    begin
        present_next     = present_reg;
        last_winner_next = last_winner_reg;
        any_winner_next  = any_winner_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        best_vld_next    = best_vld_reg;
        best_idx_next    = best_idx_reg;
        best_credit_next = best_credit_reg;
        best_above_next  = best_above_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        granted_next     = granted_reg;
        ram_we           = 1'b0;
        ram_waddr        = worker_idx;
        ram_wdata        = initial_credit_reg;
        ram_raddr        = worker_idx;

        if (cand_take)
        begin
            best_vld_next    = 1'b1;
            best_idx_next    = cmp_idx_reg;
            best_credit_next = ram_rdata;
            best_above_next  = cand_above;
        end

        case (state_reg)
            cwa_pkg::S_EXEC:
            begin
                granted_next = '0;
                case (op_reg)
                    cwa_pkg::OP_ADD:
                    begin
                        done_next = 1'b1;
                        if (!in_range)
                        begin
                            status_next = cwa_pkg::ST_ABSENT;
                        end
                        else if (present_reg[worker_idx])
                        begin
                            status_next = cwa_pkg::ST_PRESENT;
                        end
                        else
                        begin
                            status_next              = cwa_pkg::ST_OK;
                            present_next[worker_idx] = 1'b1;
                            ram_we                   = 1'b1;
                        end
                    end
                    cwa_pkg::OP_REMOVE:
                    begin
                        done_next = 1'b1;
                        if (worker_present)
                        begin
                            status_next              = cwa_pkg::ST_OK;
                            present_next[worker_idx] = 1'b0;
                        end
                        else
                        begin
                            status_next = cwa_pkg::ST_ABSENT;
                        end
                    end
                    cwa_pkg::OP_GRANT:
                    begin
                        scan_idx_next = '0;
                        cmp_vld_next  = 1'b0;
                        best_vld_next = 1'b0;
                    end
                    default:
                    begin
                        // Return: the credit read for worker_idx is issued here.
                    end
                endcase
            end
            cwa_pkg::S_RETURN:
            begin
                done_next = 1'b1;
                if (worker_present)
                begin
                    status_next = cwa_pkg::ST_OK;
                    if (ram_rdata != cwa_pkg::CREDIT_MAX)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata + 1'b1;
                    end
                end
                else
                begin
                    status_next = cwa_pkg::ST_ABSENT;
                end
            end
            cwa_pkg::S_SCAN:
            begin
                ram_raddr     = scan_idx_reg;
                cmp_idx_next  = scan_idx_reg;
                cmp_vld_next  = 1'b1;
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            cwa_pkg::S_SCAN_END:
            begin
                cmp_vld_next = 1'b0;
            end
            cwa_pkg::S_GRANT:
            begin
                done_next = 1'b1;
                if (best_vld_reg)
                begin
                    status_next      = cwa_pkg::ST_OK;
                    granted_next     = cwa_pkg::WORKER_W'(best_idx_reg);
                    ram_we           = 1'b1;
                    ram_waddr        = best_idx_reg;
                    ram_wdata        = best_credit_reg - 1'b1;
                    last_winner_next = best_idx_reg;
                    any_winner_next  = 1'b1;
                end
                else
                begin
                    status_next = cwa_pkg::ST_NOCREDIT;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= cwa_pkg::S_IDLE;
            initial_credit_reg <= cwa_pkg::INIT_CREDIT_RST;
            present_reg        <= '0;
            last_winner_reg    <= '0;
            any_winner_reg     <= 1'b0;
            cmp_vld_reg        <= 1'b0;
            best_vld_reg       <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            present_reg     <= present_next;
            last_winner_reg <= last_winner_next;
            any_winner_reg  <= any_winner_next;
            cmp_vld_reg     <= cmp_vld_next;
            best_vld_reg    <= best_vld_next;
            done_reg        <= done_next;
            if (initial_credit_we)
            begin
                initial_credit_reg <= initial_credit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= cwa_pkg::op_t'(operation);
            worker_reg <= worker;
        end
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_credit_reg <= best_credit_next;
        best_above_reg  <= best_above_next;
        status_reg      <= status_next;
        granted_reg     <= granted_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_worker = granted_reg;

    // A result beat only ends a command that kept the block busy.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding busy command");

    // An accepted command always makes the sequencer busy in the cycle after it.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not make the block busy");

    // Every failing result reports worker zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != cwa_pkg::ST_OK)) |-> (granted_worker == '0))
        else $error("failed result carries a nonzero worker");

    // A successful grant names a slot that is present.
    a_grant_present: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (op_reg == cwa_pkg::OP_GRANT) && (status == cwa_pkg::ST_OK))
        |-> present_reg[best_idx_reg])
        else $error("grant went to an absent slot");

endmodule

// ===== design/cwa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module cwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
